>>> sv/utf8d_pkg.sv
package utf8d_pkg;

   // Widths of the word fields and of the decoder state.
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned CODE_W      = 21;
   localparam int unsigned REMAIN_W    = 2;
   localparam int unsigned CONT_BITS   = 6;

   // Lead byte masks and patterns.
   localparam logic [BYTE_W-1:0] ASCII_MAX    = 8'h7F;
   localparam logic [BYTE_W-1:0] LEAD2_MASK   = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD2_PAT    = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD3_MASK   = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD3_PAT    = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD4_MASK   = 8'hF8;
   localparam logic [BYTE_W-1:0] LEAD4_PAT    = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD2_DATA   = 8'h1F;
   localparam logic [BYTE_W-1:0] LEAD3_DATA   = 8'h0F;
   localparam logic [BYTE_W-1:0] LEAD4_DATA   = 8'h07;

   // Value given out in place of a sequence cut short by the end of text.
   localparam logic [CODE_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

   // Continuation counts announced by each lead class.
   localparam logic [REMAIN_W-1:0] REMAIN_NONE  = 2'd0;
   localparam logic [REMAIN_W-1:0] REMAIN_ONE   = 2'd1;
   localparam logic [REMAIN_W-1:0] REMAIN_TWO   = 2'd2;
   localparam logic [REMAIN_W-1:0] REMAIN_THREE = 2'd3;

   typedef enum logic [2:0] {
      LEAD_ASCII,
      LEAD_TWO,
      LEAD_THREE,
      LEAD_FOUR,
      LEAD_INVALID
   } lead_class_type;

   // Sequence state carried from one word to the next.
   typedef struct packed {
      logic [CODE_W-1:0]   partial;
      logic [REMAIN_W-1:0] remain;
   } seq_state_type;

   // Outcome of decoding one word.
   typedef struct packed {
      logic                emit;
      logic [CODE_W-1:0]   scalar;
      logic                was_truncated;
      logic                ends_text;
      seq_state_type       next_state;
   } decode_type;

   // Sort a byte seen with no sequence open into its lead class.
   function automatic lead_class_type classify_lead(input logic [BYTE_W-1:0] b);
      lead_class_type cls;
      if (b <= ASCII_MAX) begin
         cls = LEAD_ASCII;
      end else if ((b & LEAD2_MASK) == LEAD2_PAT) begin
         cls = LEAD_TWO;
      end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
         cls = LEAD_THREE;
      end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
         cls = LEAD_FOUR;
      end else begin
         cls = LEAD_INVALID;
      end
      return cls;
   endfunction

endpackage

>>> sv/utf8d_decode.sv
module utf8d_decode (
   input  utf8d_pkg::seq_state_type              cur_state,
   input  logic [utf8d_pkg::BYTE_W-1:0]          text_byte,
   input  logic                                  final_byte,
   output utf8d_pkg::decode_type                 result
);
   import utf8d_pkg::*;

   lead_class_type           lead_class;
   logic [CODE_W-1:0]        merged;
   logic [REMAIN_W-1:0]      remain_dec;
   logic [CODE_W-1:0]        lead_value;
   logic [REMAIN_W-1:0]      lead_remain;

   // Shift the gathered bits up and merge the low six bits of this byte.
   assign merged     = {cur_state.partial[CODE_W-CONT_BITS-1:0],
                        text_byte[CONT_BITS-1:0]};
   assign remain_dec = cur_state.remain - REMAIN_ONE;
   assign lead_class = classify_lead(text_byte);

   // Start value and continuation count for a lead byte.
   always_comb begin
      unique case (lead_class)
         LEAD_TWO: begin
            lead_value  = CODE_W'(text_byte & LEAD2_DATA);
            lead_remain = REMAIN_ONE;
         end
         LEAD_THREE: begin
            lead_value  = CODE_W'(text_byte & LEAD3_DATA);
            lead_remain = REMAIN_TWO;
         end
         LEAD_FOUR: begin
            lead_value  = CODE_W'(text_byte & LEAD4_DATA);
            lead_remain = REMAIN_THREE;
         end
         default: begin
            lead_value  = CODE_W'(text_byte);
            lead_remain = REMAIN_NONE;
         end
      endcase
   end

   // Decide whether this word yields a result and what state it leaves.
   always_comb begin
      result               = '0;
      result.next_state    = cur_state;
      result.ends_text     = final_byte;
      if (cur_state.remain != REMAIN_NONE) begin
         if (remain_dec == REMAIN_NONE) begin
            result.emit       = 1'b1;
            result.scalar     = merged;
            result.next_state = '0;
         end else if (final_byte) begin
            result.emit          = 1'b1;
            result.scalar        = REPLACEMENT_CP;
            result.was_truncated = 1'b1;
            result.next_state    = '0;
         end else begin
            result.next_state.partial = merged;
            result.next_state.remain  = remain_dec;
         end
      end else begin
         priority if (lead_class == LEAD_ASCII) begin
            result.emit       = 1'b1;
            result.scalar     = lead_value;
         end else if (lead_class == LEAD_INVALID) begin
            // Stray continuation or impossible lead: dropped, state kept idle.
            result.emit = 1'b0;
         end else if (final_byte) begin
            result.emit          = 1'b1;
            result.scalar        = REPLACEMENT_CP;
            result.was_truncated = 1'b1;
            result.next_state    = '0;
         end else begin
            result.next_state.partial = lead_value;
            result.next_state.remain  = lead_remain;
         end
      end
   end

endmodule

>>> sv/utf8_byte_stream_decoder.sv
// A word accepted into the input register is decoded there, and any code point
// that it yields is written to the result register, which drives the outputs.
// Throughput: one byte per cycle; the input register, the decode logic and
// the result register advance together whenever the result register is free.
// Reset (synchronous, active high) clears the valid flags and closes any open
// sequence, so the next byte begins a new text.
module utf8_byte_stream_decoder (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [utf8d_pkg::BYTE_W-1:0]       req_text_byte,
   input  logic                               req_final_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [utf8d_pkg::CODE_W-1:0]       rsp_scalar,
   output logic                               rsp_was_truncated,
   output logic                               rsp_ends_text
);
   import utf8d_pkg::*;

   logic                  in_valid_ff;
   logic                  in_valid_in;
   logic [BYTE_W-1:0]     in_byte_ff;
   logic                  in_final_ff;
   seq_state_type         seq_ff;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   logic [CODE_W-1:0]     out_code_ff;
   logic                  out_trunc_ff;
   logic                  out_ends_ff;
   logic                  out_free;
   logic                  advance;
   logic                  accept;
   decode_type            dec;

   // The result register can take a new word when empty or being drained.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   // Input register.
   assign in_valid_in = accept || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff  <= req_text_byte;
         in_final_ff <= req_final_byte;
      end
   end

   // Classify, shift and merge.
   utf8d_decode u_decode (
      .cur_state  (seq_ff),
      .text_byte  (in_byte_ff),
      .final_byte (in_final_ff),
      .result     (dec)
   );

   // Sequence state moves on as each word leaves the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= '0;
      end else if (advance) begin
         seq_ff <= dec.next_state;
      end
   end

   // Result register.
   assign out_valid_in = advance ? dec.emit : (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && dec.emit) begin
         out_code_ff  <= dec.scalar;
         out_trunc_ff <= dec.was_truncated;
         out_ends_ff  <= dec.ends_text;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_scalar        = out_code_ff;
   assign rsp_was_truncated = out_trunc_ff;
   assign rsp_ends_text     = out_ends_ff;

   // The input side is only held back by a full input register.
   a_stall_needs_word: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("input stalled with an empty input register");

   // A final byte always leaves no sequence open.
   a_final_closes: assert property (@(posedge clock) disable iff (reset)
      (advance && in_final_ff) |=> (seq_ff.remain == REMAIN_NONE))
      else $error("sequence still open after the final byte");

   // With no sequence open no partial bits are kept.
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      (seq_ff.remain == REMAIN_NONE) |-> (seq_ff.partial == '0))
      else $error("partial bits held with no sequence open");

   // A replacement is always the replacement character at the end of text.
   a_trunc_form: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_trunc_ff) |->
         (out_ends_ff && (out_code_ff == REPLACEMENT_CP)))
      else $error("malformed replacement word");

   // A result held under stall keeps its value.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |=> (out_valid_ff && $stable(out_code_ff)))
      else $error("stalled result changed");

endmodule

>>> test/utf8_byte_stream_decoder_tb.sv
module utf8_byte_stream_decoder_tb;
   import utf8d_pkg::*;

   localparam int unsigned N_RANDOM_WORDS = 550;
   localparam int unsigned QUIET_LIMIT    = 2000;
   localparam int unsigned DRAIN_CYCLES   = 10;

   // One decoded character as it leaves the block.
   typedef struct packed {
      logic [CODE_W-1:0] scalar;
      logic              was_truncated;
      logic              ends_text;
   } decoded_char_type;

   // Tracks the open sequence, predicts each character and checks it on arrival.
   class char_tracker;
      decoded_char_type    due_chars[$];
      logic [CODE_W-1:0]   partial = '0;
      logic [REMAIN_W-1:0] remain  = REMAIN_NONE;
      int                  chars_matched;
      int                  cut_chars;
      int                  mismatches;

      function void take_byte(logic [BYTE_W-1:0] b, logic fin);
         decoded_char_type c;
         bit               produced;
         produced = 1'b0;
         c = '0;
         if (remain != REMAIN_NONE) begin
            // Inside a sequence every word is a continuation; only its low six bits count.
            partial = {partial[CODE_W-CONT_BITS-1:0], b[CONT_BITS-1:0]};
            remain  = remain - REMAIN_ONE;
            if (remain == REMAIN_NONE) begin
               c = '{scalar: partial, was_truncated: 1'b0, ends_text: fin};
               produced = 1'b1;
               partial = '0;
            end
         end else begin
            casez (b)
               8'b0???????: begin
                  c = '{scalar: CODE_W'(b), was_truncated: 1'b0, ends_text: fin};
                  produced = 1'b1;
               end
               8'b110?????: begin
                  partial = CODE_W'(b[4:0]);
                  remain  = REMAIN_ONE;
               end
               8'b1110????: begin
                  partial = CODE_W'(b[3:0]);
                  remain  = REMAIN_TWO;
               end
               8'b11110???: begin
                  partial = CODE_W'(b[2:0]);
                  remain  = REMAIN_THREE;
               end
               // Stray continuations and 0xF8 upwards are dropped without a trace.
               default: ;
            endcase
         end
         // A sequence still open at the last word of the text becomes one replacement.
         if (fin && remain != REMAIN_NONE) begin
            c = '{scalar: REPLACEMENT_CP, was_truncated: 1'b1, ends_text: 1'b1};
            produced = 1'b1;
            partial = '0;
            remain  = REMAIN_NONE;
         end
         if (produced)
            due_chars.insert(due_chars.size(), c);
      endfunction

      function void match_char(logic [CODE_W-1:0] cp, logic trunc, logic ends);
         decoded_char_type want;
         if (due_chars.size() == 0) begin
            $error("Character with none expected: scalar %h", cp);
            mismatches++;
            return;
         end
         want = due_chars.pop_front();
         chars_matched++;
         if (want.was_truncated)
            cut_chars++;
         if (cp !== want.scalar) begin
            $error("scalar: expected %h, got %h", want.scalar, cp);
            mismatches++;
         end
         if (trunc !== want.was_truncated) begin
            $error("was_truncated: expected %b, got %b", want.was_truncated, trunc);
            mismatches++;
         end
         if (ends !== want.ends_text) begin
            $error("ends_text: expected %b, got %b", want.ends_text, ends);
            mismatches++;
         end
      endfunction
   endclass

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_stall;
   logic [BYTE_W-1:0]   req_text_byte  = '0;
   logic                req_final_byte = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall      = 1'b0;
   logic [CODE_W-1:0]   rsp_scalar;
   logic                rsp_was_truncated;
   logic                rsp_ends_text;

   char_tracker         sb;
   logic [BYTE_W-1:0]   text_bytes[$];
   int                  words_sent;
   int                  texts_sent;
   int                  req_gap_pct;
   int                  rsp_stall_pct;
   int unsigned         quiet_cycles;

   utf8_byte_stream_decoder i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_text_byte     (req_text_byte),
      .req_final_byte    (req_final_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_scalar        (rsp_scalar),
      .rsp_was_truncated (rsp_was_truncated),
      .rsp_ends_text     (rsp_ends_text)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Every accepted input word feeds the predictor.
   always @(posedge clock) begin
      if (!reset && req_valid && req_stall === 1'b0)
         sb.take_byte(req_text_byte, req_final_byte);
   end

   // Every accepted result word is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         sb.match_char(rsp_scalar, rsp_was_truncated, rsp_ends_text);
   end

   // The receiver holds off in bursts that start at random at the current rate.
   always begin
      @(posedge clock);
      if ($urandom_range(1, 100) <= rsp_stall_pct) begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         rsp_stall <= 1'b0;
      end
   end

   // Give up if neither side moves a word for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Present one word, perhaps after an idle burst, and hold it until taken.
   task automatic send_word(input logic [BYTE_W-1:0] b, input logic fin);
      if ($urandom_range(1, 100) <= req_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_text_byte  <= b;
      req_final_byte <= fin;
      @(posedge clock);
      while (req_stall !== 1'b0)
         @(posedge clock);
      words_sent++;
   endtask

   // Send the gathered bytes as one text, flagging the last one.
   task automatic send_text();
      int i;
      for (i = 0; i < text_bytes.size(); i++)
         send_word(text_bytes[i], i == text_bytes.size() - 1);
      if (text_bytes.size() != 0)
         texts_sent++;
      text_bytes.delete();
   endtask

   function automatic logic [BYTE_W-1:0] continuation_byte();
      // Now and then the continuation slot carries a byte that looks like a lead.
      if ($urandom_range(0, 9) == 0)
         return BYTE_W'($urandom);
      return {2'b10, 6'($urandom)};
   endfunction

   // Append one character of random content, mostly well formed.
   task automatic append_char();
      int                kind;
      int                n_cont;
      int                k;
      logic [BYTE_W-1:0] lead;
      kind   = $urandom_range(0, 19);
      n_cont = 0;
      if (kind <= 5) begin
         lead = BYTE_W'($urandom_range(0, 127));
      end else if (kind <= 9) begin
         lead   = {3'b110, 5'($urandom)};
         n_cont = 1;
      end else if (kind <= 13) begin
         lead   = {4'b1110, 4'($urandom)};
         n_cont = 2;
      end else if (kind <= 16) begin
         lead   = {5'b11110, 3'($urandom)};
         n_cont = 3;
      end else if (kind == 17) begin
         if ($urandom_range(0, 1) == 0)
            lead = BYTE_W'($urandom_range(8'h80, 8'hBF));
         else
            lead = BYTE_W'($urandom_range(8'hF8, 8'hFF));
      end else if (kind == 18) begin
         lead = BYTE_W'($urandom);
      end else begin
         // A sequence short of continuations swallows whatever follows it.
         lead   = {5'b11110, 3'($urandom)};
         n_cont = $urandom_range(0, 2);
      end
      text_bytes.insert(text_bytes.size(), lead);
      for (k = 0; k < n_cont; k++)
         text_bytes.insert(text_bytes.size(), continuation_byte());
   endtask

   initial begin
      int n_chars;
      int n_cut;
      int c;
      sb = new();
      req_gap_pct   = 20;
      rsp_stall_pct = 10;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // ASCII extremes, the last one ending its text.
      text_bytes = '{8'h00, 8'h7F};
      send_text();
      // Smallest two byte form, largest three byte form, largest four byte value.
      text_bytes = '{8'hC0, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'hF7, 8'hBF, 8'hBF, 8'hBF};
      send_text();
      // Invalid leads are dropped, including one on the final word.
      text_bytes = '{8'h80, 8'hF8, 8'hFF};
      send_text();
      // Text ends in the middle of a three byte sequence.
      text_bytes = '{8'hE2, 8'h82};
      send_text();
      // A four byte lead that is itself the final word.
      text_bytes = '{8'hF3};
      send_text();
      // Continuation slots holding lead-like and all-ones bytes.
      text_bytes = '{8'hC2, 8'hF5, 8'hDF, 8'hFF, 8'h41};
      send_text();

      // Random texts with random idling, then a stretch with none at the end.
      while (words_sent < N_RANDOM_WORDS) begin
         if (words_sent > N_RANDOM_WORDS - 80) begin
            req_gap_pct   = 0;
            rsp_stall_pct = 0;
         end else begin
            case ($urandom_range(0, 3))
               0: begin
                  req_gap_pct   = 0;
                  rsp_stall_pct = 0;
               end
               1: begin
                  req_gap_pct   = 5;
                  rsp_stall_pct = 5;
               end
               2: begin
                  req_gap_pct   = 30;
                  rsp_stall_pct = 20;
               end
               default: begin
                  req_gap_pct   = $urandom_range(0, 40);
                  rsp_stall_pct = $urandom_range(0, 40);
               end
            endcase
         end
         n_chars = $urandom_range(1, 16);
         for (c = 0; c < n_chars; c++)
            append_char();
         // Cut the text short now and then, often inside its last sequence.
         if ($urandom_range(0, 5) == 0 && text_bytes.size() > 1) begin
            n_cut = $urandom_range(1, 3);
            while (n_cut > 0 && text_bytes.size() > 1) begin
               void'(text_bytes.pop_back());
               n_cut--;
            end
         end
         send_text();
      end

      // Drain: wait for every predicted character, then a little longer.
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.due_chars.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Decoded %0d words in %0d texts into %0d characters, %0d of them replacements.",
               words_sent, texts_sent, sb.chars_matched, sb.cut_chars);
      if (sb.mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

>>> sim.f
sv/utf8d_pkg.sv
sv/utf8d_decode.sv
sv/utf8_byte_stream_decoder.sv
test/utf8_byte_stream_decoder_tb.sv
